// ===== rtl/led_blink_scheduler_assert.svh =====
// Assertion macros for the LED blink scheduler.
`ifndef LED_BLINK_SCHEDULER_ASSERT_SVH
`define LED_BLINK_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define LBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("led_blink_scheduler assertion failed");
`define LBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("led_blink_scheduler assertion failed");
`else
`define LBS_ASSERT_SAME(label, ante, cons)
`define LBS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/lbs_pkg.sv =====
// Shared types and constants of the LED blink scheduler.
`default_nettype none
package lbs_pkg;

  localparam int TIME_BITS = 32;
  localparam int MS_W      = 16;
  localparam int TPM_W     = 10;
  localparam int CNT_W     = 16;
  localparam int PROD_W    = MS_W + TPM_W;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    REQ_POLL  = 3'd0,
    REQ_ON    = 3'd1,
    REQ_OFF   = 3'd2,
    REQ_TIMED = 3'd3,
    REQ_BLINK = 3'd4,
    REQ_CHECK = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TIMED = 2'd1,
    MODE_BLINK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_IDLE_ON  = 2'd0,
    CFG_IDLE_OFF = 2'd1,
    CFG_TICKS    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [MS_W-1:0]  idle_on_ms;
    logic [MS_W-1:0]  idle_off_ms;
    logic [TPM_W-1:0] ticks_per_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       req;
    time_t            now;
    logic             act;
    logic             on_zero;
    logic             off_zero;
    time_t            on_ticks;
    time_t            off_ticks;
    logic [CNT_W-1:0] count;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/lbs_in_if.sv =====
// Input channel of the LED blink scheduler.
`default_nettype none
interface lbs_in_if;
  import lbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       req_type;
  logic [31:0]      now_tick;
  logic             run_active;
  logic [MS_W-1:0]  lit_ms;
  logic [MS_W-1:0]  off_ms;
  logic [CNT_W-1:0] pulse_cnt;
  modport source (output valid, req_type, now_tick, run_active, lit_ms, off_ms,
                  pulse_cnt, input ready);
  modport sink (input valid, req_type, now_tick, run_active, lit_ms, off_ms,
                pulse_cnt, output ready);
endinterface
`default_nettype wire

// ===== rtl/lbs_out_if.sv =====
// Result channel of the LED blink scheduler.
`default_nettype none
interface lbs_out_if;
  logic       valid;
  logic       ready;
  logic       led_lit;
  logic [1:0] drv_mode;
  modport source (output valid, led_lit, drv_mode, input ready);
  modport sink (input valid, led_lit, drv_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/lbs_cfg_if.sv =====
// Configuration write channel of the LED blink scheduler.
`default_nettype none
interface lbs_cfg_if;
  import lbs_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      index;
  logic [MS_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/led_blink_scheduler.sv =====
// Top level of the LED blink scheduler.
// An accepted beat is held in the input register of lbs_front; its result then goes to the result register of lbs_core.
// Throughput: one beat per cycle while out_ch.ready does not stall; the LED state is computed combinationally.
// The input register and the result register let a new beat enter while a result waits.
// Reset (synchronous, active low) clears the LED state and restores the register defaults.
`default_nettype none
module led_blink_scheduler (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_ch,
  lbs_out_if.source out_ch,
  lbs_cfg_if.sink   cfg_ch
);
  import lbs_pkg::*;

  `include "led_blink_scheduler_assert.svh"

  cfg_t  cfg;
  item_t itm;
  logic  itm_valid;
  logic  take;

  lbs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .take      (take),
    .itm_valid (itm_valid),
    .itm       (itm)
  );

  lbs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .itm_valid (itm_valid),
    .itm       (itm),
    .take      (take),
    .out_ch    (out_ch)
  );

  `LBS_ASSERT_SAME(a_timed_is_lit, out_ch.valid && (out_ch.drv_mode == MODE_TIMED), out_ch.led_lit)
  `LBS_ASSERT_NEXT(a_beat_held, in_ch.valid && in_ch.ready, itm_valid)
  `LBS_ASSERT_NEXT(a_take_fills_out, take, out_ch.valid)

endmodule
`default_nettype wire

// ===== rtl/lbs_cfg_regs.sv =====
// Configuration registers of the LED blink scheduler.
`default_nettype none
module lbs_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  lbs_cfg_if.sink       cfg_ch,
  output lbs_pkg::cfg_t cfg
);
  import lbs_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_on_ms   <= MS_W'(1000);
      cfg_r.idle_off_ms  <= MS_W'(1000);
      cfg_r.ticks_per_ms <= TPM_W'(10);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDLE_ON:  cfg_r.idle_on_ms   <= cfg_ch.data;
        CFG_IDLE_OFF: cfg_r.idle_off_ms  <= cfg_ch.data;
        CFG_TICKS:    cfg_r.ticks_per_ms <= cfg_ch.data[TPM_W-1:0];
        default:      ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbs_front.sv =====
// Input register stage: captures a beat and converts its durations to ticks.
`default_nettype none
module lbs_front (
  input  logic           clk,
  input  logic           rst_n,
  lbs_in_if.sink         in_ch,
  input  lbs_pkg::cfg_t  cfg,
  input  logic           take,
  output logic           itm_valid,
  output lbs_pkg::item_t itm
);
  import lbs_pkg::*;

  logic              s1_v_r;
  item_t             itm_r;
  item_t             itm_nxt;
  logic              poll;
  logic [MS_W-1:0]   on_ms;
  logic [MS_W-1:0]   off_ms_sel;
  logic [PROD_W-1:0] on_prod;
  logic [PROD_W-1:0] off_prod;
  logic              accept;

  assign in_ch.ready = !s1_v_r || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign itm_valid   = s1_v_r;
  assign itm         = itm_r;

  always_comb begin
    poll       = (in_ch.req_type == REQ_POLL);
    on_ms      = poll ? cfg.idle_on_ms : in_ch.lit_ms;
    off_ms_sel = poll ? cfg.idle_off_ms : in_ch.off_ms;
    on_prod    = {{TPM_W{1'b0}}, on_ms} * {{MS_W{1'b0}}, cfg.ticks_per_ms};
    off_prod   = {{TPM_W{1'b0}}, off_ms_sel} * {{MS_W{1'b0}}, cfg.ticks_per_ms};
    itm_nxt.req       = in_ch.req_type;
    itm_nxt.now       = time_t'(in_ch.now_tick);
    itm_nxt.act       = in_ch.run_active;
    itm_nxt.on_zero   = (on_ms == '0);
    itm_nxt.off_zero  = (off_ms_sel == '0);
    itm_nxt.on_ticks  = time_t'(on_prod);
    itm_nxt.off_ticks = time_t'(off_prod);
    itm_nxt.count     = poll ? '0 : in_ch.pulse_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (take) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      itm_r <= itm_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbs_core.sv =====
// LED state update and result register.
`default_nettype none
module lbs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           itm_valid,
  input  lbs_pkg::item_t itm,
  output logic           take,
  lbs_out_if.source      out_ch
);
  import lbs_pkg::*;

  typedef struct packed {
    logic             lit;
    mode_t            mode;
    logic             phase_on;
    time_t            deadline;
    time_t            on_ticks;
    time_t            off_ticks;
    logic [CNT_W-1:0] remaining;
    logic             known;
    logic             last;
  } st_t;

  st_t        st_r;
  st_t        st_nxt;
  logic       out_v_r;
  logic       out_lit_r;
  logic [1:0] out_mode_r;
  logic       fresh;
  logic       timing;
  logic       reached;
  time_t      sum_new_on;
  time_t      sum_old_on;
  time_t      sum_off;
  time_t      diff;

  function automatic st_t set_level(st_t s, logic v);
    st_t r;
    r           = s;
    r.lit       = v;
    r.mode      = MODE_IDLE;
    r.phase_on  = 1'b0;
    r.deadline  = '0;
    r.on_ticks  = '0;
    r.off_ticks = '0;
    r.remaining = '0;
    return r;
  endfunction

  assign take           = itm_valid && (!out_v_r || out_ch.ready);
  assign out_ch.valid   = out_v_r;
  assign out_ch.led_lit  = out_lit_r;
  assign out_ch.drv_mode = out_mode_r;

  always_comb begin
    st_nxt     = st_r;
    fresh      = 1'b0;
    timing     = 1'b0;
    sum_new_on = itm.now + itm.on_ticks;
    sum_old_on = itm.now + st_r.on_ticks;
    diff       = itm.now - st_r.deadline;
    case (itm.req)
      REQ_POLL: begin
        if (!st_r.known || (st_r.last != itm.act)) begin
          st_nxt.known = 1'b1;
          st_nxt.last  = itm.act;
          if (itm.act) begin
            st_nxt = set_level(st_nxt, 1'b1);
          end else if (itm.on_zero || itm.off_zero) begin
            st_nxt = set_level(st_nxt, 1'b0);
          end else begin
            st_nxt.lit       = 1'b1;
            st_nxt.mode      = MODE_BLINK;
            st_nxt.phase_on  = 1'b1;
            st_nxt.on_ticks  = itm.on_ticks;
            st_nxt.off_ticks = itm.off_ticks;
            st_nxt.remaining = itm.count;
            st_nxt.deadline  = sum_new_on;
            fresh            = 1'b1;
          end
        end
        timing = 1'b1;
      end
      REQ_ON:  st_nxt = set_level(st_nxt, 1'b1);
      REQ_OFF: st_nxt = set_level(st_nxt, 1'b0);
      REQ_TIMED: begin
        if (itm.on_zero) begin
          st_nxt = set_level(st_nxt, 1'b0);
        end else begin
          st_nxt          = set_level(st_nxt, 1'b1);
          st_nxt.mode     = MODE_TIMED;
          st_nxt.deadline = sum_new_on;
        end
      end
      REQ_BLINK: begin
        if (itm.on_zero || itm.off_zero) begin
          st_nxt = set_level(st_nxt, 1'b0);
        end else begin
          st_nxt.lit       = 1'b1;
          st_nxt.mode      = MODE_BLINK;
          st_nxt.phase_on  = 1'b1;
          st_nxt.on_ticks  = itm.on_ticks;
          st_nxt.off_ticks = itm.off_ticks;
          st_nxt.remaining = itm.count;
          st_nxt.deadline  = sum_new_on;
        end
      end
      REQ_CHECK: timing = 1'b1;
      default:   ;
    endcase

    // A freshly started blink has its deadline one on time ahead of now.
    reached = fresh ? (itm.on_ticks == '0) : !diff[TIME_BITS-1];
    sum_off = itm.now + (fresh ? itm.off_ticks : st_r.off_ticks);

    if (timing && (st_nxt.mode != MODE_IDLE) && reached) begin
      if (st_nxt.mode == MODE_TIMED) begin
        st_nxt = set_level(st_nxt, 1'b0);
      end else if (st_nxt.phase_on) begin
        st_nxt.lit      = 1'b0;
        st_nxt.phase_on = 1'b0;
        st_nxt.deadline = sum_off;
      end else if (st_nxt.remaining == CNT_W'(1)) begin
        st_nxt = set_level(st_nxt, 1'b0);
      end else begin
        if (st_nxt.remaining != '0) begin
          st_nxt.remaining = st_nxt.remaining - CNT_W'(1);
        end
        st_nxt.lit      = 1'b1;
        st_nxt.phase_on = 1'b1;
        st_nxt.deadline = sum_old_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      out_v_r <= 1'b0;
    end else if (take) begin
      st_r    <= st_nxt;
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_lit_r  <= st_nxt.lit;
      out_mode_r <= st_nxt.mode;
    end
  end

endmodule
`default_nettype wire
